// ----- hw/rtl/wshc_pkg.sv -----
// Shared types, op and status codes for the window stack hit/clip core.
// No dependencies; every module in hw/rtl imports it.
`default_nettype none
package wshc_pkg;
    localparam int MaxWindowsDef = 16;
    localparam int CoordBitsDef  = 16;

    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_RAISE  = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_GEOM   = 3'd3;
    localparam logic [2:0] OP_HIT    = 3'd4;
    localparam logic [2:0] OP_CLIP   = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNKNOWN  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NO_HIT   = 3'd3;
    localparam logic [2:0] ST_OBSCURED = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic [3:0]         window_id;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic [14:0]        extent_w;
        logic [14:0]        extent_h;
        logic [7:0]         border_width;
        logic               start_in_background;
        logic signed [15:0] clip_right;
        logic signed [15:0] clip_bottom;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         hit_window;
        logic signed [15:0] local_x;
        logic signed [15:0] local_y;
        logic               needs_redraw;
        logic signed [15:0] out_left;
        logic signed [15:0] out_top;
        logic signed [15:0] out_right;
        logic signed [15:0] out_bottom;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE, S_FIND, S_WALK, S_SHIFT, S_DONE
    } t_state;

    // Saturate a wide signed value into 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767)       r = 16'sh7fff;
        else if (v < -20'sd32768) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/wshc_queue.sv -----
// Two-entry queue of input words between the front accept stage and the back engine.
// Depends on wshc_pkg.
`default_nettype none
module wshc_queue
    import wshc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_word i_data,
    input  wire logic     i_pop,
    output logic          o_full,
    output logic          o_empty,
    output t_in_word      o_data
);
    t_in_word   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_data  = r_mem[r_rp];

    // Advance pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/wshc_engine.sv -----
// Back engine: walks the window stack one entry a cycle for hit, raise, remove, clip.
// Depends on wshc_pkg.
`default_nettype none
module wshc_engine
    import wshc_pkg::*;
#(
    parameter int MAX_WINDOWS = MaxWindowsDef
)(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_word i_word,
    output logic          o_pop,
    output logic          o_res_valid,
    output t_out_word     o_res,
    input  wire logic     i_res_take
);
    localparam int IW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CW = $clog2(MAX_WINDOWS + 1);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_WINDOWS);

    // window tables, stack order array
    logic signed [15:0] r_left [MAX_WINDOWS];
    logic signed [15:0] r_top  [MAX_WINDOWS];
    logic [14:0]        r_wid  [MAX_WINDOWS];
    logic [14:0]        r_hgt  [MAX_WINDOWS];
    logic [7:0]         r_brd  [MAX_WINDOWS];
    logic [IW-1:0]      r_ord  [MAX_WINDOWS];
    logic [MAX_WINDOWS-1:0] r_used;
    logic [CW-1:0]      r_cnt;

    t_state r_state, n_state;
    t_in_word r_cmd;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_pos;
    logic r_hit, r_ov, r_obsc;
    logic [IW-1:0] r_hs;
    logic signed [19:0] r_lx, r_ly, r_l, r_t, r_r, r_b;
    logic r_res_valid;
    t_out_word r_res;

    logic [IW-1:0] cmd_s;
    logic id_ok, known;
    assign cmd_s = IW'(r_cmd.window_id);
    assign id_ok = ({28'd0, r_cmd.window_id} < 32'(MAX_WINDOWS));
    assign known = id_ok && r_used[cmd_s];

    // current stack entry and the commanded window
    logic [IW-1:0] w;
    logic signed [19:0] wl, wt, wr, wb, sl, st, sr, sb, inl, intop;
    assign w     = r_ord[r_i[IW-1:0]];
    assign wl    = 20'(r_left[w]);
    assign wt    = 20'(r_top[w]);
    assign wr    = wl + 20'($signed({1'b0, r_wid[w]})) - 20'sd1;
    assign wb    = wt + 20'($signed({1'b0, r_hgt[w]})) - 20'sd1;
    assign sl    = 20'(r_left[cmd_s]);
    assign st    = 20'(r_top[cmd_s]);
    assign sr    = sl + 20'($signed({1'b0, r_wid[cmd_s]})) - 20'sd1;
    assign sb    = st + 20'($signed({1'b0, r_hgt[cmd_s]})) - 20'sd1;
    assign inl   = wl + 20'($signed({1'b0, r_brd[w]}));
    assign intop = wt + 20'($signed({1'b0, r_brd[w]}));

    logic signed [19:0] cx, cy;
    assign cx = 20'(r_cmd.coord_x);
    assign cy = 20'(r_cmd.coord_y);

    logic at_end;
    assign at_end = r_i >= r_cnt;

    // Overlap of a higher window with the clipped one, then clip step.
    logic signed [19:0] ol, ot, orr, ob, nl, nt, nr, nb;
    logic meets, clip_hit;
    always_comb begin
        meets = (st <= wb) && (sb >= wt) && (sl <= wr) && (sr >= wl);
        ol = (sl > wl) ? sl : wl;
        ot = (st > wt) ? st : wt;
        orr = (sr < wr) ? sr : wr;
        ob = (sb < wb) ? sb : wb;
        clip_hit = meets && (r_t <= ob) && (r_b >= ot) && (r_l <= orr) && (r_r >= ol);
        nl = r_l; nt = r_t; nr = r_r; nb = r_b;
        if (clip_hit) begin
            if (r_l >= ol) nl = orr + 20'sd1; else nr = ol - 20'sd1;
            if (r_t >= ot) nt = ob + 20'sd1; else nb = ot - 20'sd1;
        end
    end

    // Geometry clamp against the bottom window; the bottom window itself is never clamped.
    logic [IW-1:0] rb;
    logic geo_self;
    logic signed [19:0] gl, gt, gr, gb, rr_, rb_, gw, gh, b2;
    logic [14:0] gwid, ghgt;
    always_comb begin
        rb  = r_ord[0];
        geo_self = (rb == cmd_s);
        rr_ = 20'(r_left[rb]) + 20'($signed({1'b0, r_wid[rb]})) - 20'sd1;
        rb_ = 20'(r_top[rb]) + 20'($signed({1'b0, r_hgt[rb]})) - 20'sd1;
        gl  = (!geo_self && cx < 20'(r_left[rb])) ? 20'(r_left[rb]) : cx;
        gt  = (!geo_self && cy < 20'(r_top[rb])) ? 20'(r_top[rb]) : cy;
        gr  = gl + 20'($signed({1'b0, r_cmd.extent_w})) - 20'sd1;
        gb  = gt + 20'($signed({1'b0, r_cmd.extent_h})) - 20'sd1;
        b2  = 20'($signed({2'b0, r_brd[cmd_s], 1'b0}));
        gwid = r_cmd.extent_w;
        ghgt = r_cmd.extent_h;
        gw = rr_ - gl + 20'sd1;
        if (gw > b2) gw = gw - b2;
        gh = rb_ - gt + 20'sd1;
        if (gh > b2) gh = gh - b2;
        if (!geo_self && gr > rr_) gwid = gw[19] ? 15'd0 : gw[14:0];
        if (!geo_self && gb > rb_) ghgt = gh[19] ? 15'd0 : gh[14:0];
    end

    logic start;
    assign start = (r_state == S_IDLE) && i_valid;
    assign o_pop = start;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_FIND;
            S_FIND: begin
                if (r_cmd.op == OP_HIT) n_state = S_WALK;
                else if (r_cmd.op == OP_CREATE || r_cmd.op > OP_CLIP || !known
                         || r_cmd.op == OP_GEOM) n_state = S_DONE;
                else if (at_end || w == cmd_s) n_state = S_WALK;
            end
            S_WALK: if (at_end || (r_cmd.op == OP_CLIP && r_obsc)) n_state = S_SHIFT;
            S_SHIFT: if (r_cmd.op != OP_RAISE && r_cmd.op != OP_REMOVE
                         || r_i + 1'b1 >= r_cnt) n_state = S_DONE;
            S_DONE: if (!r_res_valid || i_res_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Walk datapath and table updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_cnt  <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_cmd <= i_word;
                    r_i <= '0; r_hit <= 1'b0; r_ov <= 1'b0; r_obsc <= 1'b0;
                    r_l <= 20'(i_word.coord_x); r_t <= 20'(i_word.coord_y);
                    r_r <= 20'(i_word.clip_right); r_b <= 20'(i_word.clip_bottom);
                end
                S_FIND: begin
                    if (r_cmd.op == OP_CREATE) begin
                        if (id_ok && !r_used[cmd_s] && r_cnt < MaxCnt) begin
                            r_left[cmd_s] <= r_cmd.coord_x;
                            r_top[cmd_s]  <= r_cmd.coord_y;
                            r_wid[cmd_s]  <= r_cmd.extent_w;
                            r_hgt[cmd_s]  <= r_cmd.extent_h;
                            r_brd[cmd_s]  <= r_cmd.border_width;
                            r_used[cmd_s] <= 1'b1;
                            r_cnt <= r_cnt + 1'b1;
                            if (r_cmd.start_in_background) begin
                                for (int k = MAX_WINDOWS - 1; k > 0; k--)
                                    r_ord[k] <= r_ord[k-1];
                                r_ord[0] <= cmd_s;
                            end else begin
                                r_ord[r_cnt[IW-1:0]] <= cmd_s;
                            end
                        end
                    end else if (r_cmd.op == OP_GEOM && known) begin
                        r_left[cmd_s] <= gl[15:0];
                        r_top[cmd_s]  <= gt[15:0];
                        r_wid[cmd_s]  <= gwid;
                        r_hgt[cmd_s]  <= ghgt;
                    end else if (r_cmd.op != OP_HIT && known) begin
                        if (at_end || w == cmd_s) begin
                            r_pos <= r_i;
                            r_i <= r_i + 1'b1;
                        end else r_i <= r_i + 1'b1;
                    end
                end
                S_WALK: if (!at_end) begin
                    r_i <= r_i + 1'b1;
                    if (r_cmd.op == OP_HIT) begin
                        if (cx >= inl && cx <= inl + 20'($signed({1'b0, r_wid[w]}))
                            && cy >= intop
                            && cy <= intop + 20'($signed({1'b0, r_hgt[w]}))) begin
                            r_hit <= 1'b1; r_hs <= w;
                            r_lx <= cx - inl; r_ly <= cy - intop;
                        end
                    end else if (r_cmd.op == OP_RAISE) begin
                        if (meets) r_ov <= 1'b1;
                    end else if (r_cmd.op == OP_CLIP && !r_obsc) begin
                        r_l <= nl; r_t <= nt; r_r <= nr; r_b <= nb;
                        if (clip_hit && (nt > nb || nl > nr)) r_obsc <= 1'b1;
                    end
                end else begin
                    r_i <= r_pos;
                end
                S_SHIFT: if (r_cmd.op == OP_RAISE || r_cmd.op == OP_REMOVE) begin
                    // Close the gap one entry a cycle.
                    if (r_i + 1'b1 < r_cnt) begin
                        r_ord[r_i[IW-1:0]] <= r_ord[IW'(r_i + 1'b1)];
                        r_i <= r_i + 1'b1;
                    end else if (r_cmd.op == OP_RAISE) begin
                        r_ord[IW'(r_cnt - 1'b1)] <= cmd_s;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                        r_used[cmd_s] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Assemble the result word.
    t_out_word res;
    always_comb begin
        res = '0;
        case (r_cmd.op)
            OP_CREATE: begin
                if (!id_ok) res.status = ST_UNKNOWN;
                else if (r_used[cmd_s] && r_state == S_FIND) res.status = ST_FULL;
            end
            OP_HIT: begin
                if (!r_hit) res.status = ST_NO_HIT;
                else begin
                    res.hit_window = 4'(r_hs);
                    res.local_x = sat16(r_lx);
                    res.local_y = sat16(r_ly);
                end
            end
            OP_RAISE, OP_REMOVE, OP_GEOM: begin
                if (!known && r_state == S_FIND) res.status = ST_UNKNOWN;
                res.needs_redraw = (r_cmd.op == OP_RAISE) && r_ov;
            end
            OP_CLIP: begin
                if (!known && r_state == S_FIND) res.status = ST_UNKNOWN;
                else if (r_obsc) res.status = ST_OBSCURED;
                else begin
                    res.out_left = sat16(r_l); res.out_top = sat16(r_t);
                    res.out_right = sat16(r_r); res.out_bottom = sat16(r_b);
                end
            end
            default: ;
        endcase
    end

    // Create failure must be decided before the table changes; latch it at FIND.
    logic r_cfail;
    logic [2:0] r_early;
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIND) begin
            r_cfail <= (r_cmd.op == OP_CREATE) && id_ok && (r_used[cmd_s] || r_cnt >= MaxCnt);
            r_early <= res.status;
        end
    end

    // Merge the early status into the final word.
    t_out_word fin;
    always_comb begin
        fin = res;
        if (r_cmd.op == OP_CREATE) begin
            fin.status = r_cfail ? ST_FULL : r_early;
        end else if (r_early == ST_UNKNOWN && r_cmd.op <= OP_CLIP && r_cmd.op != OP_HIT) begin
            fin = '0;
            fin.status = ST_UNKNOWN;
        end
    end

    // Hold the output register until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_res_valid <= 1'b0;
        else if (r_state == S_DONE && (!r_res_valid || i_res_take)) begin
            r_res_valid <= 1'b1;
            r_res <= fin;
        end else if (r_res_valid && i_res_take) begin
            r_res_valid <= 1'b0;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res = r_res;
endmodule
`default_nettype wire

// ----- hw/rtl/window_stack_hit_clip_core.sv -----
// Top level: input queue feeding the stack engine, registered result word.
// Depends on wshc_pkg, wshc_queue, wshc_engine.
//
//  channel | valid      | stall      | payload
//  in      | i_in_valid | o_in_stall | i_in_word (t_in_word)
//  out     | o_out_valid| i_out_stall| o_out_word (t_out_word)
//
// Create, geometry and unknown-window items need no walk. For a hit test,
// raise, remove or clip the engine walks the stack order one entry a
// cycle to find the window and scan higher ones; raise and remove then
// close the gap. Reset clears slot use and stack count; window tables
// are undefined until written. The two-entry queue takes up to two words
// while the engine works or the output is stalled.
`default_nettype none
module window_stack_hit_clip_core
    import wshc_pkg::*;
#(
    parameter int MAX_WINDOWS = MaxWindowsDef
)(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_word i_in_word,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_word     o_out_word
);
    logic q_full, q_empty, q_pop;
    t_in_word q_data;

    assign o_in_stall = q_full;

    wshc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_in_valid && !q_full), .i_data(i_in_word),
        .i_pop(q_pop), .o_full(q_full), .o_empty(q_empty), .o_data(q_data)
    );

    wshc_engine #(.MAX_WINDOWS(MAX_WINDOWS)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(!q_empty), .i_word(q_data), .o_pop(q_pop),
        .o_res_valid(o_out_valid), .o_res(o_out_word),
        .i_res_take(!i_out_stall)
    );

    // Engine never pops an empty queue.
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("pop on empty queue");
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result dropped under stall");
endmodule
`default_nettype wire
